/* src/assert_macros.svh */
// Assertion macros used by the checker file tcc_checker.sv.
// Each macro expands to one labeled concurrent assertion on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* src/tcc_pkg.sv */
// Shared constants, codes and types of the transposed convolution channel unit.
// Used by every module of the block; depends on nothing.
package tcc_pkg;

    localparam int MAX_TAPS     = 16;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_STRIDE   = 16;
    localparam int SAMPLE_BITS  = 16;

    localparam int RING_DEPTH = (MAX_STRIDE > MAX_TAPS) ? MAX_STRIDE : MAX_TAPS;
    localparam int ACC_BITS   = 40;
    localparam int PROD_BITS  = 2 * SAMPLE_BITS;
    localparam int OUT_BITS   = 32;
    localparam int BIAS_BITS  = 32;
    localparam int CFG_BITS   = 5;
    localparam int CH_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W      = $clog2(MAX_STRIDE + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_STRIDE = 2'd0;
    localparam logic [1:0] CFG_TAPS   = 2'd1;
    localparam logic [1:0] CFG_BIAS   = 2'd2;

    // Item commands.
    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_ACT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mul_en;
        logic acc_en;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

/* src/transposed_conv1d_channel_unit.sv */
// Top level of one output channel of a strided transposed 1-D convolution.
// Depends on tcc_pkg, tcc_cell and tcc_out.
//
// Use: configuration writes (stride, taps, bias) go over the cfg channel, which
// is always ready; write it only while the block is idle. Input items arrive on
// the in channel: a weight item (command 0) loads one channel/tap weight, and the
// input stays ready after it. An activation item is multiplied into the chain of
// accumulator cells, one cell per tap, all taps at once, in three steps (weight
// read, multiply, accumulate), and the input is not ready again until it is done.
// An activation that closes a time step then shifts stride finished sums out of
// the head of the chain, one per cycle while the output register is free, into
// the output register; the emit state that follows the accumulate state loads
// the first result. When the receiver stalls, the output register holds its
// item and the chain waits; the next input item is still taken once the last
// result sits in the output register.
// A frame-end mark clears the whole chain on the last shift of its step.
// Reset (synchronous, active low) clears the pending sums, the output register
// and the registers to stride 1, taps 1, bias 0; weights are undefined until
// written.
module transposed_conv1d_channel_unit import tcc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [BIAS_BITS-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [3:0]                    i_channel,
    input  logic [3:0]                    i_tap,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_step_done,
    input  logic                          i_frame_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_BITS-1:0]    o_out_value,
    output logic                          o_last
);

    logic [CFG_BITS-1:0]           r_stride;
    logic [CFG_BITS-1:0]           r_taps;
    logic signed [BIAS_BITS-1:0]   r_bias;
    t_state                        r_state;
    t_state                        n_state;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [RING_DEPTH-1:0]         r_cell_en;
    logic                          r_step_done;
    logic                          r_frame_end;
    logic [CNT_W-1:0]              r_cnt;

    logic                          w_in_acc;
    logic                          w_chan_ok;
    logic                          w_tap_ok;
    logic [CNT_W-1:0]              w_s_eff;
    logic                          w_out_free;
    logic                          w_emit;
    logic                          w_final;
    logic [CH_IDX_W-1:0]           w_addr;
    t_cell_ctl                     w_ctl [RING_DEPTH];
    logic signed [ACC_BITS-1:0]    w_sum [RING_DEPTH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= CFG_BITS'(1);
            r_taps   <= CFG_BITS'(1);
            r_bias   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STRIDE: r_stride <= i_cfg_data[CFG_BITS-1:0];
                CFG_TAPS:   r_taps   <= i_cfg_data[CFG_BITS-1:0];
                CFG_BIAS:   r_bias   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_chan_ok = int'(i_channel) < MAX_CHANNELS;
    assign w_tap_ok  = int'(i_tap) < MAX_TAPS;
    assign w_addr    = CH_IDX_W'(i_channel);
    assign w_emit    = (r_state == ST_EMIT) && w_out_free;
    assign w_final   = r_cnt == CNT_W'(1);

    // Stride zero runs as one, and a stride above the chain's range is clamped.
    always_comb begin
        if (r_stride == '0) begin
            w_s_eff = CNT_W'(1);
        end else if (int'(r_stride) > MAX_STRIDE) begin
            w_s_eff = CNT_W'(MAX_STRIDE);
        end else begin
            w_s_eff = CNT_W'(r_stride);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_cnt <= w_s_eff;
            end else if (w_emit) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x         <= i_sample;
            r_step_done <= i_step_done;
            r_frame_end <= i_frame_end;
            for (int j = 0; j < RING_DEPTH; j++) begin
                r_cell_en[j] <= w_chan_ok && (j < MAX_TAPS) && (j < int'(r_taps));
            end
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_command == CMD_ACT)) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = r_step_done ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (w_emit && w_final) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        for (int j = 0; j < RING_DEPTH; j++) begin
            w_ctl[j].wr_en  = w_in_acc && (i_command == CMD_WEIGHT) && w_chan_ok
                              && w_tap_ok && (int'(i_tap) == j);
            w_ctl[j].rd_en  = w_in_acc && (i_command == CMD_ACT);
            w_ctl[j].mul_en = (r_state == ST_MUL);
            w_ctl[j].acc_en = (r_state == ST_ACC) && r_cell_en[j];
            w_ctl[j].shift  = w_emit;
            w_ctl[j].clear  = w_emit && w_final && r_frame_end;
        end
    end

    for (genvar j = 0; j < RING_DEPTH; j++) begin : g_cell
        logic signed [ACC_BITS-1:0] w_next;

        if (j == RING_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_sum[j+1];
        end

        tcc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[j]),
            .i_addr     (w_addr),
            .i_wdata    (i_sample),
            .i_x        (r_x),
            .i_next_sum (w_next),
            .o_sum      (w_sum[j])
        );
    end

    tcc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_sum   (w_sum[0]),
        .i_bias  (r_bias),
        .i_last  (w_final),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_value (o_out_value),
        .o_last  (o_last),
        .o_free  (w_out_free)
    );

endmodule

/* src/tcc_cell.sv */
// One cell of the accumulator chain: weight column, multiplier and pending sum.
// Depends on tcc_pkg.
module tcc_cell import tcc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cell_ctl                   i_ctl,
    input  logic [CH_IDX_W-1:0]         i_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wdata,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [ACC_BITS-1:0]  i_next_sum,
    output logic signed [ACC_BITS-1:0]  o_sum
);

    logic signed [SAMPLE_BITS-1:0] r_wmem [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_w;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_sum;
    logic signed [ACC_BITS-1:0]    n_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_wmem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_w <= r_wmem[i_addr];
        end
        if (i_ctl.mul_en) begin
            r_prod <= PROD_BITS'(i_x) * PROD_BITS'(r_w);
        end
    end

    // Clearing wins over shifting; the sum wraps at the accumulator width.
    always_comb begin
        priority if (i_ctl.clear) begin
            n_sum = '0;
        end else if (i_ctl.shift) begin
            n_sum = i_next_sum;
        end else if (i_ctl.acc_en) begin
            n_sum = r_sum + {{(ACC_BITS - PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* src/tcc_out.sv */
// Output stage: adds the bias, saturates to 32 bits and holds the result item.
// Depends on tcc_pkg.
module tcc_out import tcc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [ACC_BITS-1:0]  i_sum,
    input  logic signed [BIAS_BITS-1:0] i_bias,
    input  logic                        i_last,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic signed [OUT_BITS-1:0]  o_value,
    output logic                        o_last,
    output logic                        o_free
);

    localparam int W = ACC_BITS + 1;

    logic signed [W-1:0]        w_total;
    logic                       w_fits;
    logic signed [OUT_BITS-1:0] w_sat;
    logic                       r_valid;
    logic signed [OUT_BITS-1:0] r_value;
    logic                       r_last;

    assign w_total = W'(i_sum) + W'(i_bias);

    // The value fits when every bit above the output sign bit copies it.
    assign w_fits = (&w_total[W-1:OUT_BITS-1]) || !(|w_total[W-1:OUT_BITS-1]);

    always_comb begin
        if (w_fits) begin
            w_sat = w_total[OUT_BITS-1:0];
        end else if (w_total[W-1]) begin
            w_sat = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(OUT_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= w_sat;
            r_last  <= i_last;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

/* src/tcc_checker.sv */
// Port-level checker for the transposed convolution channel unit, bound to the top.
// Depends on tcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcc_checker import tcc_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_command,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [OUT_BITS-1:0]    o_out_value,
    input logic                          o_last
);

    // A result item that is not taken stays, unchanged.
    `TCC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value) && $stable(o_last), "result item changed while stalled")

    // Reset leaves no result item behind.
    `TCC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // An activation item keeps the block busy for its multiply-accumulate.
    `TCC_ASSERT(a_act_busy, i_in_valid && o_in_ready && i_command == CMD_ACT |=> !o_in_ready, "input ready right after an activation item")

    // The input stays ready after a weight item.
    `TCC_ASSERT(a_wgt_fast, i_in_valid && o_in_ready && i_command == CMD_WEIGHT |=> o_in_ready, "input not ready after a weight item")

endmodule

bind transposed_conv1d_channel_unit tcc_checker u_tcc_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for transposed_conv1d_channel_unit, with random idling on both sides.
// Depends on tcc_pkg and the unit's RTL. A built-in channel model predicts every output item.
module tb_top;
    import tcc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 60;
    localparam int RAND_PHASES   = 3;
    localparam int PHASE_ITEMS   = 50;
    localparam int BIG_STEPS     = 4;
    localparam int BIG_ACTS      = 6;

    // Index 3 is not a register; writes to it must leave the block unchanged.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [BIAS_BITS-1:0] BIAS_MIN = {1'b1, {(BIAS_BITS-1){1'b0}}};
    localparam logic [BIAS_BITS-1:0] BIAS_MAX = {1'b0, {(BIAS_BITS-1){1'b1}}};
    localparam longint OUT_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< (OUT_BITS - 1));

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_HOLD
    } t_op_kind;

    typedef struct {
        t_op_kind                      kind;
        logic                          command;
        logic [3:0]                    channel;
        logic [3:0]                    tap;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          step_done;
        logic                          frame_end;
        logic [1:0]                    cfg_index;
        logic [BIAS_BITS-1:0]          cfg_data;
    } t_conv_op;

    typedef struct {
        logic signed [OUT_BITS-1:0] value;
        logic                       closing;
    } t_out_item;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index = '0;
    logic [BIAS_BITS-1:0]          i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic                          i_command   = 1'b0;
    logic [3:0]                    i_channel   = '0;
    logic [3:0]                    i_tap       = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                          i_step_done = 1'b0;
    logic                          i_frame_end = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [OUT_BITS-1:0]    o_out_value;
    logic                          o_last;

    // Channel model state.
    logic signed [SAMPLE_BITS-1:0] coef [MAX_CHANNELS][MAX_TAPS];
    logic [ACC_BITS-1:0]           partial [RING_DEPTH] = '{default: '0};
    int                            ring_head  = 0;
    logic [CFG_BITS-1:0]           stride_reg = CFG_BITS'(1);
    logic [CFG_BITS-1:0]           taps_reg   = CFG_BITS'(1);
    logic signed [BIAS_BITS-1:0]   bias_reg   = '0;

    t_out_item expected_outputs [$];
    t_conv_op  pending_ops [$];
    t_conv_op  cur_op;
    bit        op_live   = 1'b0;
    bit        op_sent   = 1'b0;
    bit        stim_done = 1'b0;
    int        gap_left;
    int        settle_left;
    int        sink_stall  = 0;
    int        feed_calm   = 0;
    int        sink_calm   = 0;
    int        cycle_count = 0;
    int        mismatch_count = 0;

    transposed_conv1d_channel_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_channel   (i_channel),
        .i_tap       (i_tap),
        .i_sample    (i_sample),
        .i_step_done (i_step_done),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[cycle %0d] mismatch: %s", cycle_count, what);
        end
    endtask

    // Applies one accepted item to the model and queues the outputs it releases.
    function automatic void tconv_predict(input t_conv_op it);
        int        s_eff;
        int        t_eff;
        int        d;
        int        idx;
        longint    prod;
        longint    total;
        t_out_item res;
        if (it.command == CMD_WEIGHT) begin
            coef[it.channel][it.tap] = it.smp;
            return;
        end
        s_eff = (stride_reg == 0) ? 1 :
                ((stride_reg > MAX_STRIDE) ? MAX_STRIDE : int'(stride_reg));
        t_eff = (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
        if (it.channel < MAX_CHANNELS) begin
            for (d = 0; d < t_eff; d++) begin
                idx = (ring_head + d) % RING_DEPTH;
                prod = longint'(it.smp) * longint'(coef[it.channel][d]);
                partial[idx] = partial[idx] + ACC_BITS'(prod);
            end
        end
        if (!it.step_done) begin
            return;
        end
        for (d = 0; d < s_eff; d++) begin
            idx = (ring_head + d) % RING_DEPTH;
            total = longint'($signed(partial[idx])) + longint'(bias_reg);
            if (total > OUT_MAX) begin
                total = OUT_MAX;
            end
            if (total < OUT_MIN) begin
                total = OUT_MIN;
            end
            partial[idx] = '0;
            res.value = OUT_BITS'(total);
            res.closing = (d == s_eff - 1);
            expected_outputs.push_back(res);
        end
        ring_head = (ring_head + s_eff) % RING_DEPTH;
        // The frame end drops the tail that no later step will finish.
        if (it.frame_end) begin
            foreach (partial[k]) begin
                partial[k] = '0;
            end
            ring_head = 0;
        end
    endfunction

    function automatic void tconv_write_reg(input logic [1:0] index,
                                            input logic [BIAS_BITS-1:0] data);
        case (index)
            CFG_STRIDE: stride_reg = data[CFG_BITS-1:0];
            CFG_TAPS:   taps_reg   = data[CFG_BITS-1:0];
            CFG_BIAS:   bias_reg   = data;
            default:    ;
        endcase
    endfunction

    // Idle cycles before the next item, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic void push_op(input t_op_kind kind, input logic cmd,
                                    input logic [3:0] ch, input logic [3:0] tp,
                                    input logic signed [SAMPLE_BITS-1:0] smp,
                                    input logic sd, input logic fe,
                                    input logic [1:0] index,
                                    input logic [BIAS_BITS-1:0] data);
        t_conv_op op;
        op.kind      = kind;
        op.command   = cmd;
        op.channel   = ch;
        op.tap       = tp;
        op.smp       = smp;
        op.step_done = sd;
        op.frame_end = fe;
        op.cfg_index = index;
        op.cfg_data  = data;
        pending_ops.push_back(op);
    endfunction

    // Weight items carry random step and frame flags, which the block must ignore.
    function automatic void push_weight(input logic [3:0] ch, input logic [3:0] tp,
                                        input logic signed [SAMPLE_BITS-1:0] smp);
        push_op(OP_ITEM, CMD_WEIGHT, ch, tp, smp, 1'($urandom()), 1'($urandom()), '0, '0);
    endfunction

    function automatic void push_act(input logic [3:0] ch,
                                     input logic signed [SAMPLE_BITS-1:0] smp,
                                     input logic sd, input logic fe);
        push_op(OP_ITEM, CMD_ACT, ch, 4'($urandom()), smp, sd, fe, '0, '0);
    endfunction

    function automatic void push_cfg(input logic [1:0] index,
                                     input logic [BIAS_BITS-1:0] data);
        push_op(OP_CFG, CMD_WEIGHT, '0, '0, '0, 1'b0, 1'b0, index, data);
    endfunction

    function automatic void push_hold();
        push_op(OP_HOLD, CMD_WEIGHT, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Stride or taps value, including zero and values above the supported range.
    function automatic logic [CFG_BITS-1:0] pick_span();
        case ($urandom_range(0, 7))
            0:       return CFG_BITS'(0);
            1:       return CFG_BITS'(1);
            2:       return CFG_BITS'(16);
            3:       return CFG_BITS'($urandom_range(17, 31));
            default: return CFG_BITS'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [BIAS_BITS-1:0] pick_bias();
        case ($urandom_range(0, 5))
            0:       return BIAS_MAX;
            1:       return BIAS_MIN;
            2:       return '0;
            3:       return $urandom();
            default: return BIAS_BITS'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic void build_stimulus();
        int  ph;
        int  ch;
        int  tp;
        int  st;
        int  a;
        int  count;
        int  hold_at;
        int  nsteps;
        int  nact;
        bit  held;
        bit  drop_end;
        logic sd;
        logic fe;

        // Fill the whole weight store so that no activation reads an unwritten entry.
        for (ch = 0; ch < MAX_CHANNELS; ch++) begin
            for (tp = 0; tp < MAX_TAPS; tp++) begin
                push_weight(4'(ch), 4'(tp), pick_sample());
            end
        end

        push_cfg(CFG_STRIDE, 32'd2);
        push_cfg(CFG_TAPS, 32'd3);
        push_cfg(CFG_BIAS, '0);
        push_weight(4'd0, 4'd0, SAMPLE_MAX);
        push_weight(4'd0, 4'd1, SAMPLE_MIN);
        push_weight(4'd0, 4'd2, 16'sd1);
        push_act(4'd0, SAMPLE_MAX, 1'b0, 1'b0);
        push_act(4'd0, SAMPLE_MIN, 1'b1, 1'b0);
        push_act(4'd0, 16'sh0100, 1'b0, 1'b1);
        push_act(4'd15, -16'sd1, 1'b1, 1'b1);

        // Stride zero acts as one; taps zero adds nothing, so the bias alone comes out.
        push_cfg(CFG_STRIDE, 32'd0);
        push_cfg(CFG_TAPS, 32'd0);
        push_cfg(CFG_BIAS, BIAS_MAX);
        push_act(4'd7, SAMPLE_MAX, 1'b1, 1'b0);
        push_act(4'd9, SAMPLE_MIN, 1'b1, 1'b1);

        push_cfg(CFG_STRIDE, {27'($urandom()), 5'd31});
        push_cfg(CFG_TAPS, {27'($urandom()), 5'd31});
        push_cfg(CFG_BIAS, BIAS_MIN);
        push_cfg(CFG_SPARE, $urandom());
        push_act(4'd0, SAMPLE_MIN, 1'b0, 1'b0);
        push_act(4'd0, SAMPLE_MIN, 1'b0, 1'b0);
        push_act(4'd0, SAMPLE_MIN, 1'b1, 1'b0);
        push_act(4'd15, SAMPLE_MAX, 1'b1, 1'b1);

        // Steps of full-scale products build pending sums far beyond the output range.
        push_cfg(CFG_STRIDE, 32'd1);
        push_cfg(CFG_TAPS, 32'd16);
        push_cfg(CFG_BIAS, '0);
        for (tp = 0; tp < MAX_TAPS; tp++) begin
            push_weight(4'd15, 4'(tp), SAMPLE_MIN);
        end
        for (st = 0; st < BIG_STEPS; st++) begin
            for (a = 0; a < BIG_ACTS; a++) begin
                push_act(4'd15, SAMPLE_MIN, a == BIG_ACTS - 1,
                         (a == BIG_ACTS - 1) && (st == BIG_STEPS - 1));
            end
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            push_cfg(CFG_STRIDE, {27'($urandom()), pick_span()});
            push_cfg(CFG_TAPS, {27'($urandom()), pick_span()});
            push_cfg(CFG_BIAS, pick_bias());
            count = 0;
            held = 1'b0;
            hold_at = $urandom_range(10, PHASE_ITEMS - 10);
            while (count < PHASE_ITEMS) begin
                nsteps = $urandom_range(1, 6);
                // Now and then a frame runs on without its end mark.
                drop_end = ($urandom_range(0, 7) == 0);
                for (st = 0; st < nsteps; st++) begin
                    nact = $urandom_range(1, 5);
                    for (a = 0; a < nact; a++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            push_weight(4'($urandom()), 4'($urandom()), pick_sample());
                            count++;
                        end
                        sd = (a == nact - 1);
                        fe = sd && (st == nsteps - 1) && !drop_end;
                        if (!sd && $urandom_range(0, 11) == 0) begin
                            fe = 1'b1;
                        end
                        push_act(4'($urandom()), pick_sample(), sd, fe);
                        count++;
                        if (!held && count >= hold_at) begin
                            push_hold();
                            held = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    // Sender: one op at a time from the pending queue.
    always @(posedge i_clk) begin
        logic nxt_in_valid;
        logic nxt_cfg_valid;
        cycle_count++;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            op_live = 1'b0;
        end else begin
            nxt_in_valid  = i_in_valid;
            nxt_cfg_valid = i_cfg_valid;
            if (i_in_valid && o_in_ready) begin
                tconv_predict(cur_op);
                nxt_in_valid = 1'b0;
                op_live = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tconv_write_reg(cur_op.cfg_index, cur_op.cfg_data);
                nxt_cfg_valid = 1'b0;
                op_live = 1'b0;
            end
            if (!op_live && pending_ops.size() != 0) begin
                cur_op = pending_ops.pop_front();
                op_live = 1'b1;
                op_sent = 1'b0;
                gap_left = draw_wait(feed_calm);
                settle_left = SETTLE_CYCLES;
            end
            if (op_live && !op_sent) begin
                if (cur_op.kind == OP_ITEM) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        i_command   <= cur_op.command;
                        i_channel   <= cur_op.channel;
                        i_tap       <= cur_op.tap;
                        i_sample    <= cur_op.smp;
                        i_step_done <= cur_op.step_done;
                        i_frame_end <= cur_op.frame_end;
                        nxt_in_valid = 1'b1;
                        op_sent = 1'b1;
                    end
                end else if (expected_outputs.size() == 0) begin
                    // Drained; let any activation without outputs finish before going on.
                    if (settle_left > 0) begin
                        settle_left--;
                    end else if (cur_op.kind == OP_CFG) begin
                        i_cfg_index <= cur_op.cfg_index;
                        i_cfg_data  <= cur_op.cfg_data;
                        nxt_cfg_valid = 1'b1;
                        op_sent = 1'b1;
                    end else begin
                        op_live = 1'b0;
                    end
                end
            end
            if (!op_live && pending_ops.size() == 0) begin
                stim_done = 1'b1;
            end
            i_in_valid  <= nxt_in_valid;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // Receiver: random stalls and the output check.
    always @(posedge i_clk) begin
        logic      nxt_ready;
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            nxt_ready = i_out_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_outputs.size() == 0) begin
                    flag_mismatch($sformatf("output %0d (last %0b) with none expected",
                                            o_out_value, o_last));
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_out_value !== want.value) begin
                        flag_mismatch($sformatf("out_value %0d, expected %0d",
                                                o_out_value, want.value));
                    end
                    if (o_last !== want.closing) begin
                        flag_mismatch($sformatf("last %0b, expected %0b",
                                                o_last, want.closing));
                    end
                end
                sink_stall = draw_wait(sink_calm);
                nxt_ready = (sink_stall == 0);
            end else if (!i_out_ready) begin
                if (sink_stall > 0) begin
                    sink_stall--;
                end
                nxt_ready = (sink_stall == 0);
            end
            i_out_ready <= nxt_ready;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/tcc_pkg.sv
src/tcc_cell.sv
src/tcc_out.sv
src/transposed_conv1d_channel_unit.sv
src/tcc_checker.sv
tb/sv/tb_top.sv
